// File: hw/rtl/qvr_pkg.sv
// Shared constants and helpers for the quaternion vector rotation pipeline.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package qvr_pkg;

  // Quaternion components are always 16-bit signed fixed point.
  localparam int QUAT_WIDTH = 16;
  localparam int QUAT_FRAC_BITS_DEF = 14;
  localparam int VEC_WIDTH_DEF = 18;

  localparam int NUM_AXES = 3;
  localparam int NUM_COEF = NUM_AXES * NUM_AXES;

  // One product of two quaternion components.
  localparam int PROD_W = 2 * QUAT_WIDTH;
  // A rotation matrix entry: a sum of four products, or twice a sum of two.
  localparam int COEF_W = PROD_W + 2;

  // Width of the per-axis accumulator. It holds the sum of three
  // coefficient-by-vector products and also the rounding half.
  function automatic int sum_width(input int frac_bits, input int vec_width);
    int prod_sum;
    int round_need;
    prod_sum   = COEF_W + vec_width + 2;
    round_need = 2 * frac_bits + 2;
    return (prod_sum > round_need) ? prod_sum : round_need;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/quaternion_vector_rotate.sv
// Registered stages, in order: component products, matrix entries, entry-by-component products, row sums, output.
// Throughput: one item per cycle while the output is not stalled; all five stages are registered and can hold an item.
// Each stage moves forward whenever it is empty or the stage after it moves, so a
// stall on the output only fills bubbles before input ready falls.
// Reset (rst, synchronous, active high) clears every stage's valid bit; the data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module quaternion_vector_rotate #(
  parameter int QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS_DEF,
  parameter int VEC_WIDTH      = qvr_pkg::VEC_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  // Input item, from bit 0 up: quat_x, quat_y, quat_z, quat_w (16 bits each),
  // vec_x, vec_y, vec_z (VEC_WIDTH bits each), zero padding to a whole byte.
  input  logic                                                  s_tvalid,
  output logic                                                  s_tready,
  input  logic [((4*qvr_pkg::QUAT_WIDTH+3*VEC_WIDTH+7)/8)*8-1:0] s_tdata,
  // Result item, from bit 0 up: out_x, out_y, out_z (VEC_WIDTH bits each),
  // zero padding to a whole byte.
  output logic                                                  m_tvalid,
  input  logic                                                  m_tready,
  output logic [((3*VEC_WIDTH+7)/8)*8-1:0]                      m_tdata,
  // Result flag: saturated, set when any axis was clipped to the vector range.
  output logic                                                  m_tuser
);
  import qvr_pkg::*;

  localparam int QW       = QUAT_WIDTH;
  localparam int VEC_BITS = NUM_AXES * VEC_WIDTH;
  localparam int OUT_W    = ((3 * VEC_WIDTH + 7) / 8) * 8;
  localparam int SUM_W    = sum_width(QUAT_FRAC_BITS, VEC_WIDTH);

  // Matrix stages to multiply-accumulate stages.
  logic                         coef_valid;
  logic                         coef_ready;
  logic [NUM_COEF*COEF_W-1:0]   coef;
  logic [VEC_BITS-1:0]          coef_vec;

  // Multiply-accumulate stages to the output stage.
  logic                         sum_valid;
  logic                         sum_ready;
  logic [NUM_AXES*SUM_W-1:0]    sum;

  logic [VEC_BITS-1:0]          result;

  // Stages one and two: component products, then the rotation matrix entries.
  qvr_coef #(
    .VEC_WIDTH (VEC_WIDTH)
  ) u_coef (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .quat_x    (s_tdata[0*QW +: QW]),
    .quat_y    (s_tdata[1*QW +: QW]),
    .quat_z    (s_tdata[2*QW +: QW]),
    .quat_w    (s_tdata[3*QW +: QW]),
    .vec_in    (s_tdata[4*QW +: VEC_BITS]),
    .out_valid (coef_valid),
    .out_ready (coef_ready),
    .coef      (coef),
    .vec_out   (coef_vec)
  );

  // Stages three and four: matrix times vector, exact, plus the rounding half.
  qvr_mac #(
    .QUAT_FRAC_BITS (QUAT_FRAC_BITS),
    .VEC_WIDTH      (VEC_WIDTH),
    .SUM_W          (SUM_W)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (coef_valid),
    .in_ready  (coef_ready),
    .coef      (coef),
    .vec_in    (coef_vec),
    .out_valid (sum_valid),
    .out_ready (sum_ready),
    .sum       (sum)
  );

  // Stage five: shift out the fraction, clip to the vector range, flag clipping.
  qvr_round #(
    .QUAT_FRAC_BITS (QUAT_FRAC_BITS),
    .VEC_WIDTH      (VEC_WIDTH),
    .SUM_W          (SUM_W)
  ) u_round (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sum_valid),
    .in_ready  (sum_ready),
    .sum       (sum),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .vec_out   (result),
    .saturated (m_tuser)
  );

  assign m_tdata = OUT_W'(result);

endmodule

`default_nettype wire

// File: hw/rtl/qvr_coef.sv
// Rotation matrix stages: component products, then the nine matrix entries.
// Depends on qvr_pkg. Two register stages; the vector rides along unchanged.
`timescale 1ns / 1ps
`default_nettype none

module qvr_coef #(
  parameter int VEC_WIDTH = qvr_pkg::VEC_WIDTH_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        in_valid,
  output logic                                        in_ready,
  input  logic [qvr_pkg::QUAT_WIDTH-1:0]              quat_x,
  input  logic [qvr_pkg::QUAT_WIDTH-1:0]              quat_y,
  input  logic [qvr_pkg::QUAT_WIDTH-1:0]              quat_z,
  input  logic [qvr_pkg::QUAT_WIDTH-1:0]              quat_w,
  input  logic [qvr_pkg::NUM_AXES*VEC_WIDTH-1:0]      vec_in,
  output logic                                        out_valid,
  input  logic                                        out_ready,
  output logic [qvr_pkg::NUM_COEF*qvr_pkg::COEF_W-1:0] coef,
  output logic [qvr_pkg::NUM_AXES*VEC_WIDTH-1:0]      vec_out
);
  import qvr_pkg::*;

  logic signed [QUAT_WIDTH-1:0] sx, sy, sz, sw;
  logic signed [PROD_W-1:0] xx, yy, zz, ww, xy, wz, xz, wy, yz, wx;
  logic [NUM_AXES*VEC_WIDTH-1:0] vec1;
  logic valid1, valid2;
  logic ready1, ready2;
  logic signed [COEF_W-1:0] coef_next [NUM_COEF];
  logic signed [COEF_W-1:0] coef_reg [NUM_COEF];

  assign sx = $signed(quat_x);
  assign sy = $signed(quat_y);
  assign sz = $signed(quat_z);
  assign sw = $signed(quat_w);

  assign ready2   = !valid2 || out_ready;
  assign ready1   = !valid1 || ready2;
  assign in_ready = ready1;
  assign out_valid = valid2;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid2 <= 1'b0;
    end else begin
      if (ready1) valid1 <= in_valid;
      if (ready2) valid2 <= valid1;
    end
  end

  // Stage one: the ten distinct products of quaternion components.
  always_ff @(posedge clk) begin
    if (ready1) begin
      xx   <= sx * sx;
      yy   <= sy * sy;
      zz   <= sz * sz;
      ww   <= sw * sw;
      xy   <= sx * sy;
      wz   <= sw * sz;
      xz   <= sx * sz;
      wy   <= sw * sy;
      yz   <= sy * sz;
      wx   <= sw * sx;
      vec1 <= vec_in;
    end
  end

  // Stage two: the matrix entries, row by row.
  always_comb begin
    coef_next[0] = COEF_W'(ww) + COEF_W'(xx) - COEF_W'(yy) - COEF_W'(zz);
    coef_next[1] = (COEF_W'(xy) - COEF_W'(wz)) <<< 1;
    coef_next[2] = (COEF_W'(xz) + COEF_W'(wy)) <<< 1;
    coef_next[3] = (COEF_W'(xy) + COEF_W'(wz)) <<< 1;
    coef_next[4] = COEF_W'(ww) - COEF_W'(xx) + COEF_W'(yy) - COEF_W'(zz);
    coef_next[5] = (COEF_W'(yz) - COEF_W'(wx)) <<< 1;
    coef_next[6] = (COEF_W'(xz) - COEF_W'(wy)) <<< 1;
    coef_next[7] = (COEF_W'(yz) + COEF_W'(wx)) <<< 1;
    coef_next[8] = COEF_W'(ww) - COEF_W'(xx) - COEF_W'(yy) + COEF_W'(zz);
  end

  always_ff @(posedge clk) begin
    if (ready2) begin
      for (int k = 0; k < NUM_COEF; k++) begin
        coef_reg[k] <= coef_next[k];
      end
      vec_out <= vec1;
    end
  end

  for (genvar k = 0; k < NUM_COEF; k++) begin : g_pack
    assign coef[k*COEF_W +: COEF_W] = coef_reg[k];
  end

endmodule

`default_nettype wire

// File: hw/rtl/qvr_mac.sv
// Matrix-by-vector stages: nine products, then three row sums with rounding half.
// Depends on qvr_pkg. Two register stages.
`timescale 1ns / 1ps
`default_nettype none

module qvr_mac #(
  parameter int QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS_DEF,
  parameter int VEC_WIDTH      = qvr_pkg::VEC_WIDTH_DEF,
  parameter int SUM_W          = qvr_pkg::sum_width(QUAT_FRAC_BITS, VEC_WIDTH)
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         in_valid,
  output logic                                         in_ready,
  input  logic [qvr_pkg::NUM_COEF*qvr_pkg::COEF_W-1:0] coef,
  input  logic [qvr_pkg::NUM_AXES*VEC_WIDTH-1:0]       vec_in,
  output logic                                         out_valid,
  input  logic                                         out_ready,
  output logic [qvr_pkg::NUM_AXES*SUM_W-1:0]           sum
);
  import qvr_pkg::*;

  localparam int MUL_W = COEF_W + VEC_WIDTH;
  localparam int SHIFT = 2 * QUAT_FRAC_BITS;
  localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) << (SHIFT - 1);

  logic signed [COEF_W-1:0]    c [NUM_COEF];
  logic signed [VEC_WIDTH-1:0] v [NUM_AXES];
  logic signed [MUL_W-1:0]     mul [NUM_COEF];
  logic signed [SUM_W-1:0]     acc [NUM_AXES];
  logic valid3, valid4;
  logic ready3, ready4;

  for (genvar k = 0; k < NUM_COEF; k++) begin : g_coef
    assign c[k] = $signed(coef[k*COEF_W +: COEF_W]);
  end
  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    assign v[a] = $signed(vec_in[a*VEC_WIDTH +: VEC_WIDTH]);
    assign sum[a*SUM_W +: SUM_W] = acc[a];
  end

  assign ready4    = !valid4 || out_ready;
  assign ready3    = !valid3 || ready4;
  assign in_ready  = ready3;
  assign out_valid = valid4;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid3 <= 1'b0;
      valid4 <= 1'b0;
    end else begin
      if (ready3) valid3 <= in_valid;
      if (ready4) valid4 <= valid3;
    end
  end

  // Stage three: every matrix entry times its vector component.
  always_ff @(posedge clk) begin
    if (ready3) begin
      for (int r = 0; r < NUM_AXES; r++) begin
        for (int j = 0; j < NUM_AXES; j++) begin
          mul[r*NUM_AXES + j] <= c[r*NUM_AXES + j] * v[j];
        end
      end
    end
  end

  // Stage four: row sums, with the rounding half folded in.
  always_ff @(posedge clk) begin
    if (ready4) begin
      for (int r = 0; r < NUM_AXES; r++) begin
        acc[r] <= SUM_W'(mul[r*NUM_AXES]) + SUM_W'(mul[r*NUM_AXES + 1])
                + SUM_W'(mul[r*NUM_AXES + 2]) + HALF;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/qvr_round.sv
// Output stage: drops the fraction bits, clips each axis, raises the saturation flag.
// Depends on qvr_pkg. One register stage that also serves as the output register.
`timescale 1ns / 1ps
`default_nettype none

module qvr_round #(
  parameter int QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS_DEF,
  parameter int VEC_WIDTH      = qvr_pkg::VEC_WIDTH_DEF,
  parameter int SUM_W          = qvr_pkg::sum_width(QUAT_FRAC_BITS, VEC_WIDTH)
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [qvr_pkg::NUM_AXES*SUM_W-1:0]     sum,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [qvr_pkg::NUM_AXES*VEC_WIDTH-1:0] vec_out,
  output logic                                   saturated
);
  import qvr_pkg::*;

  localparam int SHIFT = 2 * QUAT_FRAC_BITS;
  localparam int TOP_W = SUM_W - VEC_WIDTH + 1;
  localparam logic [VEC_WIDTH-1:0] VMAX = {1'b0, {(VEC_WIDTH-1){1'b1}}};
  localparam logic [VEC_WIDTH-1:0] VMIN = {1'b1, {(VEC_WIDTH-1){1'b0}}};

  logic signed [SUM_W-1:0] shifted [NUM_AXES];
  logic [VEC_WIDTH-1:0] clip_next [NUM_AXES];
  logic [NUM_AXES-1:0] over;
  logic valid5;
  logic ready5;

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      shifted[a] = $signed(sum[a*SUM_W +: SUM_W]) >>> SHIFT;
      // The value fits when every bit from the result's sign bit upward agrees.
      over[a] = !((&shifted[a][SUM_W-1 -: TOP_W]) || !(|shifted[a][SUM_W-1 -: TOP_W]));
      if (!over[a]) begin
        clip_next[a] = shifted[a][VEC_WIDTH-1:0];
      end else if (shifted[a][SUM_W-1]) begin
        clip_next[a] = VMIN;
      end else begin
        clip_next[a] = VMAX;
      end
    end
  end

  assign ready5    = !valid5 || out_ready;
  assign in_ready  = ready5;
  assign out_valid = valid5;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid5 <= 1'b0;
    end else if (ready5) begin
      valid5 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready5) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        vec_out[a*VEC_WIDTH +: VEC_WIDTH] <= clip_next[a];
      end
      saturated <= |over;
    end
  end

endmodule

`default_nettype wire

// File: verif/testbench.sv
// Self-checking testbench for quaternion_vector_rotate: streams rotation items through the
// block and checks every result against a behavioral predictor kept in a small scoreboard.
// Depends on qvr_pkg and the quaternion_vector_rotate RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int QW  = qvr_pkg::QUAT_WIDTH;
  localparam int QF  = qvr_pkg::QUAT_FRAC_BITS_DEF;
  localparam int VW  = qvr_pkg::VEC_WIDTH_DEF;
  localparam int SDW = ((4 * QW + 3 * VW + 7) / 8) * 8;
  localparam int MDW = ((3 * VW + 7) / 8) * 8;

  // Cycles with no item moving on either side before the run is declared hung.
  localparam int STALL_LIMIT = 3000;
  // Long receiver hold-off that fills the pipeline and backs up the input.
  localparam int LONG_HOLD = 300;

  localparam longint VMAX = (longint'(1) <<< (VW - 1)) - 1;
  localparam longint VMIN = -VMAX - 1;

  typedef struct {
    logic signed [QW-1:0] quat_x;
    logic signed [QW-1:0] quat_y;
    logic signed [QW-1:0] quat_z;
    logic signed [QW-1:0] quat_w;
    logic signed [VW-1:0] vec_x;
    logic signed [VW-1:0] vec_y;
    logic signed [VW-1:0] vec_z;
  } rot_item_t;

  typedef struct {
    logic signed [VW-1:0] out_x;
    logic signed [VW-1:0] out_y;
    logic signed [VW-1:0] out_z;
    logic                 saturated;
  } rot_result_t;

  // Holds the rotated vectors still owed by the block, oldest first.
  class rotation_scoreboard;
    rot_result_t owed_q[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    // One axis: exact dot product of a matrix row with the vector, then add half,
    // floor on the fraction shift, and clip to the vector range.
    function logic signed [VW-1:0] round_axis(longint c0, longint c1, longint c2,
                                              longint v0, longint v1, longint v2,
                                              inout bit sat);
      longint acc;
      acc = c0 * v0 + c1 * v1 + c2 * v2 + (longint'(1) <<< (2 * QF - 1));
      acc = acc >>> (2 * QF);
      if (acc > VMAX) begin
        sat = 1'b1;
        acc = VMAX;
      end else if (acc < VMIN) begin
        sat = 1'b1;
        acc = VMIN;
      end
      return acc[VW-1:0];
    endfunction

    // Expanded rotation matrix applied to the vector; no normalization, so a
    // non-unit quaternion also scales the result by its squared norm.
    function rot_result_t rotate_vector(rot_item_t it);
      longint x, y, z, w, vx, vy, vz;
      rot_result_t r;
      bit sat;
      x  = it.quat_x;
      y  = it.quat_y;
      z  = it.quat_z;
      w  = it.quat_w;
      vx = it.vec_x;
      vy = it.vec_y;
      vz = it.vec_z;
      sat = 1'b0;
      r.out_x = round_axis(w*w + x*x - y*y - z*z, 2*(x*y - w*z), 2*(x*z + w*y),
                           vx, vy, vz, sat);
      r.out_y = round_axis(2*(x*y + w*z), w*w - x*x + y*y - z*z, 2*(y*z - w*x),
                           vx, vy, vz, sat);
      r.out_z = round_axis(2*(x*z - w*y), 2*(y*z + w*x), w*w - x*x - y*y + z*z,
                           vx, vy, vz, sat);
      r.saturated = sat;
      return r;
    endfunction

    function void note_input(rot_item_t it);
      owed_q.push_back(rotate_vector(it));
    endfunction

    function void check_result(logic [MDW-1:0] data, logic user);
      rot_result_t exp_r;
      rot_result_t act;
      act.out_x     = data[0 +: VW];
      act.out_y     = data[VW +: VW];
      act.out_z     = data[2*VW +: VW];
      act.saturated = user;
      if (owed_q.size() == 0) begin
        $error("result item with no pending input: out_x %0d out_y %0d out_z %0d",
               act.out_x, act.out_y, act.out_z);
        errors++;
        return;
      end
      exp_r = owed_q.pop_front();
      if (act.out_x !== exp_r.out_x) begin
        $error("out_x: expected %0d, actual %0d", exp_r.out_x, act.out_x);
        errors++;
      end
      if (act.out_y !== exp_r.out_y) begin
        $error("out_y: expected %0d, actual %0d", exp_r.out_y, act.out_y);
        errors++;
      end
      if (act.out_z !== exp_r.out_z) begin
        $error("out_z: expected %0d, actual %0d", exp_r.out_z, act.out_z);
        errors++;
      end
      if (act.saturated !== exp_r.saturated) begin
        $error("saturated: expected %0d, actual %0d", exp_r.saturated, act.saturated);
        errors++;
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic           clk;
  logic           rst      = 1'b1;
  logic           s_tvalid = 1'b0;
  logic           s_tready;
  logic [SDW-1:0] s_tdata  = '0;
  logic           m_tvalid;
  logic           m_tready = 1'b0;
  logic [MDW-1:0] m_tdata;
  logic           m_tuser;

  rotation_scoreboard sb;

  // Idle chances in percent for each side, changed per phase by the main sequence.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // Cycles left in a forced receiver hold-off; set by the main sequence.
  int rx_hold = 0;
  int quiet_cycles = 0;

  quaternion_vector_rotate #(
    .QUAT_FRAC_BITS(QF),
    .VEC_WIDTH(VW)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Input layout, from bit 0 up: quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z,
  // then zero padding.
  function automatic logic [SDW-1:0] pack_item(rot_item_t it);
    logic [SDW-1:0] d;
    d = '0;
    d[0 +: QW]          = it.quat_x;
    d[QW +: QW]         = it.quat_y;
    d[2*QW +: QW]       = it.quat_z;
    d[3*QW +: QW]       = it.quat_w;
    d[4*QW +: VW]       = it.vec_x;
    d[4*QW + VW +: VW]  = it.vec_y;
    d[4*QW + 2*VW +: VW] = it.vec_z;
    return d;
  endfunction

  function automatic rot_item_t make_item(int qx, int qy, int qz, int qw,
                                          int vx, int vy, int vz);
    rot_item_t it;
    it.quat_x = qx[QW-1:0];
    it.quat_y = qy[QW-1:0];
    it.quat_z = qz[QW-1:0];
    it.quat_w = qw[QW-1:0];
    it.vec_x  = vx[VW-1:0];
    it.vec_y  = vy[VW-1:0];
    it.vec_z  = vz[VW-1:0];
    return it;
  endfunction

  // A value near the corners of a signed field of the given width, or now and then a random one.
  function automatic int corner_value(int width);
    int top;
    top = (1 << (width - 1)) - 1;
    case ($urandom_range(5))
      0: return top;
      1: return -top - 1;
      2: return 0;
      3: return -1;
      4: return 1;
      default: return $urandom;
    endcase
  endfunction

  // Fully random items, plus unit rotations about one axis, small
  // magnitudes that stay clear of saturation, and corner mixes.
  function automatic rot_item_t random_item();
    rot_item_t it;
    int mode, c, s, sgn, axis;
    mode = $urandom_range(9);
    if (mode <= 3) begin
      it = make_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else if (mode <= 6) begin
      // Half-angle cosine and sine in Q1.14 for a handful of rotation angles.
      case ($urandom_range(4))
        0: begin c = 16384; s = 0;     end
        1: begin c = 11585; s = 11585; end
        2: begin c = 0;     s = 16384; end
        3: begin c = 15137; s = 6270;  end
        default: begin c = 8192; s = 14189; end
      endcase
      sgn  = $urandom_range(1) ? -1 : 1;
      axis = $urandom_range(2);
      it = make_item(axis == 0 ? sgn * s : 0, axis == 1 ? sgn * s : 0,
                     axis == 2 ? sgn * s : 0, ($urandom_range(1) ? -c : c),
                     $urandom, $urandom, $urandom);
    end else if (mode <= 8) begin
      it = make_item(int'($urandom_range(32768)) - 16384, int'($urandom_range(32768)) - 16384,
                     int'($urandom_range(32768)) - 16384, int'($urandom_range(32768)) - 16384,
                     int'($urandom_range(2000)) - 1000, int'($urandom_range(2000)) - 1000,
                     int'($urandom_range(2000)) - 1000);
    end else begin
      it = make_item(corner_value(QW), corner_value(QW), corner_value(QW), corner_value(QW),
                     corner_value(VW), corner_value(VW), corner_value(VW));
    end
    return it;
  endfunction

  // Offers one item, idling first at random, and records it once the block takes it.
  task automatic send_item(rot_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pack_item(it);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_input(it);
  endtask

  task automatic send_random(int count);
    int k;
    for (k = 0; k < count; k++) send_item(random_item());
  endtask

  // Receiver: checks each result taken at this edge, then picks ready for the next
  // cycle. A forced hold-off overrides the random idling.
  always @(posedge clk) begin
    if (m_tvalid === 1'b1 && m_tready === 1'b1) sb.check_result(m_tdata, m_tuser);
    if (rx_hold > 0) begin
      rx_hold = rx_hold - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: a run where nothing moves for too long is hung.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Phase one: slow sender, very slow receiver.
    send_idle_pct = 33;
    recv_idle_pct = 79;

    // Directed items: zero input, identity with extreme vectors, quarter and half turns,
    // full-scale quaternions that must saturate, rounding ties in both directions,
    // and non-unit quaternions.
    send_item(make_item(0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(0, 0, 0, 16384, 131071, -131072, 1));
    send_item(make_item(0, 0, 0, 16384, -131072, 131071, -1));
    send_item(make_item(0, 0, 11585, 11585, 1000, 0, 0));
    send_item(make_item(16384, 0, 0, 0, 5, 7, -9));
    send_item(make_item(32767, 32767, 32767, 32767, 131071, 131071, 131071));
    send_item(make_item(-32768, -32768, -32768, -32768, -131072, -131072, -131072));
    send_item(make_item(0, 0, 0, -32768, 131071, 131071, 131071));
    // w = 0.5 gives w^2 = 2^26, so vector parts that are twice an odd number land exactly on a half.
    send_item(make_item(0, 0, 0, 8192, 2, -2, 6));
    send_item(make_item(0, 0, 0, 8192, -6, 3, -3));
    send_item(make_item(8192, 0, 0, 8192, 100, 200, 300));
    send_item(make_item(32767, 0, 0, 0, 131071, 0, 0));
    send_item(make_item(0, -32768, 0, 0, 0, -131072, 0));
    send_item(make_item(0, 0, 32767, -32768, 1, -1, 1));
    send_item(make_item(1, 1, 1, 1, 131071, 131071, 131071));
    send_item(make_item(-1, -1, -1, -1, -131072, -131072, -131072));
    send_item(make_item(32767, -32768, 32767, -32768, -131072, 131071, -131072));
    send_random(300);

    // Phase two: the sides swap their idling; halfway the sender waits for the
    // pipeline to drain completely.
    send_idle_pct = 79;
    recv_idle_pct = 33;
    send_random(150);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    send_random(150);

    // Phase three: no idling, starting with a long receiver hold-off so the
    // pipeline fills and input ready drops while items keep coming.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rx_hold = LONG_HOLD;
    send_random(330);
    s_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    // Wait on past the five-stage pipeline to catch any stray result.
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
